// File: src/spectral_pixel_calibrate_correct_defines.svh
// ----------------------------------------------------------------------------
// Spectral pixel calibration - assertion macros
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPECTRAL_PIXEL_CALIBRATE_CORRECT_DEFINES_SVH
`define SPECTRAL_PIXEL_CALIBRATE_CORRECT_DEFINES_SVH

`ifndef SYNTHESIS
// Check that a property holds at every clock edge
`define SPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Check that a condition never occurs
`define SPC_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define SPC_ASSERT(lbl, prop, msg)
`define SPC_NEVER(lbl, cond, msg)
`endif

`endif

// File: src/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg
// Shared widths, register codes, queue entry types and saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package spc_pkg;

    localparam int IDX_W   = 12;
    localparam int CNT_W   = 16;
    localparam int LAM_W   = 28;
    localparam int VAL_W   = 32;
    localparam int GAIN_W  = 24;
    localparam int COEF_W  = 64;
    localparam int K_W     = 13;
    localparam int POLY_W  = 116;
    localparam int NUM_W   = 40;
    localparam int DEN_W   = 16;
    localparam int SIMPLE_W = 34;
    localparam int WIDE_W  = 42;
    localparam int CFG_IDX_W = 4;
    localparam int TDATA_W = 64;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam logic [LAM_W-1:0]  LAMBDA_MIN_RST = 28'd62352851;
    localparam logic [LAM_W-1:0]  LAMBDA_MAX_RST = 28'd108133745;
    localparam logic [GAIN_W-1:0] CAL_GAIN_RST   = 24'd65536;

    localparam logic signed [WIDE_W-1:0] VAL_MAX = 42'sd2147483647;
    localparam logic signed [WIDE_W-1:0] VAL_MIN = -42'sd2147483648;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEFF_INTERCEPT = 4'd0,
        REG_COEFF_LINEAR    = 4'd1,
        REG_COEFF_SQUARE    = 4'd2,
        REG_COEFF_CUBE      = 4'd3,
        REG_LAMBDA_MIN      = 4'd4,
        REG_LAMBDA_MAX      = 4'd5,
        REG_METHOD          = 4'd6,
        REG_CAL_GAIN        = 4'd7
    } t_cfg_reg;

    typedef enum logic [1:0] {
        METHOD_RAW     = 2'd0,
        METHOD_DARK    = 2'd1,
        METHOD_RATIO   = 2'd2,
        METHOD_REFLECT = 2'd3
    } t_method;

    typedef struct packed {
        logic [CNT_W-1:0] sample;
        logic [CNT_W-1:0] dark;
        logic [CNT_W-1:0] reference;
    } t_spc_pix;

    typedef struct packed {
        logic [LAM_W-1:0] lam;
        t_spc_pix         pix;
    } t_spc_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_spc_qstat;

    typedef struct packed {
        logic [LAM_W-1:0]           lam;
        logic signed [SIMPLE_W-1:0] simple;
        logic                       ratio;
        logic                       neg;
        logic                       dzero;
        logic [DEN_W-1:0]           dmag;
    } t_spc_side;

    // Clamp a wide signed value to the signed 32 bit range
    function automatic logic [VAL_W-1:0] f_sat32(input logic signed [WIDE_W-1:0] v);
        logic [VAL_W-1:0] res;
        if (v > VAL_MAX) begin
            res = VAL_MAX[VAL_W-1:0];
        end else if (v < VAL_MIN) begin
            res = VAL_MIN[VAL_W-1:0];
        end else begin
            res = v[VAL_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: src/spc_front.sv
// ----------------------------------------------------------------------------
// spc_front
// Wavelength polynomial pipeline and window check; pushes in-window pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_front import spc_pkg::*; #(
    parameter int PIXEL_OFFSET = 0,
    parameter int PIXEL_COUNT  = 4096
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire [IDX_W-1:0]         i_index,
    input  t_spc_pix                i_pix,
    input  wire [COEF_W-1:0]        i_coeff0,
    input  wire [COEF_W-1:0]        i_coeff1,
    input  wire [COEF_W-1:0]        i_coeff2,
    input  wire [COEF_W-1:0]        i_coeff3,
    input  wire [LAM_W-1:0]         i_lambda_min,
    input  wire [LAM_W-1:0]         i_lambda_max,
    input  t_spc_qstat              i_qstat,
    output logic                    o_push,
    output t_spc_item               o_item
);

    localparam int NSTG = 7;

    logic                     w_en;
    logic [NSTG-1:0]          r_v;
    t_spc_pix                 r_pix [NSTG];
    logic [K_W-1:0]           r_k1, r_k2, r_k3;
    logic [2*K_W-1:0]         r_kk2, r_kk3;
    logic [3*K_W-1:0]         r_kkk3;
    logic [COEF_W-1:0]        r_c0_4;
    logic [71:0]              r_p3lo;
    logic signed [72:0]       r_p3hi;
    logic [57:0]              r_p2lo;
    logic signed [59:0]       r_p2hi;
    logic [44:0]              r_p1lo;
    logic signed [46:0]       r_p1hi;
    logic signed [POLY_W-1:0] r_t3, r_t2, r_t1, r_t0;
    logic signed [POLY_W-1:0] r_a, r_b, r_t;
    logic [LAM_W-1:0]         w_lam;
    logic                     w_inwin;

    // Stall the whole front while the last stage waits on a full queue
    assign w_en    = !(r_v[NSTG-1] && i_qstat.full);
    assign o_ready = w_en;

    // Advance valid bits; drop pixels beyond the detector length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NSTG-2:0],
                    i_valid && ({1'b0, i_index} < K_W'(PIXEL_COUNT))};
        end
    end

    // Carry pixel counts along the stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pix[0] <= i_pix;
            for (int i = 1; i < NSTG; i++) begin
                r_pix[i] <= r_pix[i-1];
            end
        end
    end

    // Powers of k, then split coefficient products, then a two level sum
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k1   <= K_W'({1'b0, i_index} + K_W'(PIXEL_OFFSET));
            r_k2   <= r_k1;
            r_kk2  <= r_k1 * r_k1;
            r_k3   <= r_k2;
            r_kk3  <= r_kk2;
            r_kkk3 <= r_kk2 * r_k2;
            r_c0_4 <= i_coeff0;
            r_p3lo <= i_coeff3[31:0] * r_kkk3;
            r_p3hi <= $signed(i_coeff3[63:32]) * $signed({1'b0, r_kkk3});
            r_p2lo <= i_coeff2[31:0] * r_kk3;
            r_p2hi <= $signed(i_coeff2[63:32]) * $signed({1'b0, r_kk3});
            r_p1lo <= i_coeff1[31:0] * r_k3;
            r_p1hi <= $signed(i_coeff1[63:32]) * $signed({1'b0, r_k3});
            r_t3   <= (POLY_W'(r_p3hi) <<< 32) + $signed(POLY_W'(r_p3lo));
            r_t2   <= ((POLY_W'(r_p2hi) <<< 32) + $signed(POLY_W'(r_p2lo))) <<< 16;
            r_t1   <= ((POLY_W'(r_p1hi) <<< 32) + $signed(POLY_W'(r_p1lo))) <<< 32;
            r_t0   <= POLY_W'($signed(r_c0_4)) <<< 48;
            r_a    <= r_t3 + r_t2;
            r_b    <= r_t1 + r_t0;
            r_t    <= r_a + r_b;
        end
    end

    // Classify against the window on the exact sum
    assign w_lam   = r_t[75:48];
    assign w_inwin = (r_t[POLY_W-1:76] == '0) && (w_lam >= i_lambda_min)
                     && (w_lam <= i_lambda_max);

    assign o_push   = r_v[NSTG-1] && w_inwin && !i_qstat.full;
    assign o_item   = '{lam: w_lam, pix: r_pix[NSTG-1]};

endmodule

`default_nettype wire

// File: src/spc_fifo.sv
// ----------------------------------------------------------------------------
// spc_fifo
// Short request queue between the classify front and the correction back.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_fifo import spc_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_push,
    input  t_spc_item  i_item,
    input  wire        i_pop,
    output t_spc_item  o_item,
    output t_spc_qstat o_qstat
);

    t_spc_item        r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr, r_rd;
    logic [Q_AW:0]    r_cnt;

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Store requests
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_item        = r_mem[r_rd];
    assign o_qstat.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);

endmodule

`default_nettype wire

// File: src/spc_back.sv
// ----------------------------------------------------------------------------
// spc_back
// Intensity correction: mode select, gain product, pipelined divider,
// saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_back import spc_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  t_spc_qstat        i_qstat,
    input  t_spc_item         i_item,
    output logic              o_pop,
    input  wire [1:0]         i_method,
    input  wire [GAIN_W-1:0]  i_gain,
    output logic              o_valid,
    input  wire               i_ready,
    output logic [LAM_W-1:0]  o_lam,
    output logic [VAL_W-1:0]  o_value
);

    logic                  w_en;
    logic                  r_v1, r_v2;
    t_spc_item             r_it1;
    t_method               r_m1;
    t_spc_side             r_side2;
    logic [DEN_W-1:0]      r_nmag2;
    logic [NUM_W:0]        r_dv;
    t_spc_side             r_side [NUM_W+1];
    logic [DEN_W-1:0]      r_rem  [NUM_W+1];
    logic [NUM_W-1:0]      r_n    [NUM_W+1];
    logic signed [16:0]    w_sd, w_rd, w_num, w_den;
    logic                  w_ratio;
    logic signed [SIMPLE_W-1:0] w_simple;
    logic [NUM_W-1:0]      w_q;
    logic signed [WIDE_W-1:0] w_wide;
    logic                  r_ov;
    logic [LAM_W-1:0]      r_olam;
    logic [VAL_W-1:0]      r_oval;

    // Move the whole back pipeline only when the output slot frees up
    assign w_en  = !r_ov || i_ready;
    assign o_pop = w_en && !i_qstat.empty;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_dv <= '0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_v1 <= o_pop;
            r_v2 <= r_v1;
            r_dv <= {r_dv[NUM_W-1:0], r_v2};
            r_ov <= r_dv[NUM_W];
        end
    end

    // Select numerator, divisor and the direct value for the current mode
    always_comb begin
        w_sd    = $signed({1'b0, r_it1.pix.sample}) - $signed({1'b0, r_it1.pix.dark});
        w_rd    = $signed({1'b0, r_it1.pix.reference}) - $signed({1'b0, r_it1.pix.dark});
        w_ratio = (r_m1 == METHOD_RATIO) || (r_m1 == METHOD_REFLECT);
        w_num   = (r_m1 == METHOD_RATIO) ? $signed({1'b0, r_it1.pix.sample}) : w_sd;
        w_den   = (r_m1 == METHOD_RATIO) ? $signed({1'b0, r_it1.pix.reference}) : w_rd;
        if (r_m1 == METHOD_RAW) begin
            w_simple = $signed({18'b0, r_it1.pix.sample}) <<< 16;
        end else begin
            w_simple = SIMPLE_W'(w_sd) <<< 16;
        end
    end

    // Latch request, then magnitudes, then the gain product
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_it1 <= i_item;
            r_m1  <= t_method'(i_method);
            r_side2.lam    <= r_it1.lam;
            r_side2.simple <= w_simple;
            r_side2.ratio  <= w_ratio;
            r_side2.neg    <= w_num[16] ^ w_den[16];
            r_side2.dzero  <= (w_den == '0);
            r_side2.dmag   <= w_den[16] ? DEN_W'(-w_den) : w_den[DEN_W-1:0];
            r_nmag2        <= w_num[16] ? DEN_W'(-w_num) : w_num[DEN_W-1:0];
            r_side[0] <= r_side2;
            r_rem[0]  <= '0;
            r_n[0]    <= i_gain * r_nmag2;
        end
    end

    // Restoring divider, one quotient bit per stage
    for (genvar g = 0; g < NUM_W; g++) begin : g_div
        logic [DEN_W:0] w_sh;
        logic           w_ge;
        assign w_sh = {r_rem[g], r_n[g][NUM_W-1]};
        assign w_ge = (w_sh >= {1'b0, r_side[g].dmag});
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_side[g+1] <= r_side[g];
                r_rem[g+1]  <= w_ge ? DEN_W'(w_sh - {1'b0, r_side[g].dmag})
                                    : w_sh[DEN_W-1:0];
                r_n[g+1]    <= {r_n[g][NUM_W-2:0], w_ge};
            end
        end
    end

    // Apply sign, zero divisor and saturation
    always_comb begin
        w_q = r_n[NUM_W];
        if (!r_side[NUM_W].ratio) begin
            w_wide = WIDE_W'(r_side[NUM_W].simple);
        end else if (r_side[NUM_W].dzero) begin
            w_wide = '0;
        end else if (r_side[NUM_W].neg) begin
            w_wide = -$signed({2'b0, w_q});
        end else begin
            w_wide = $signed({2'b0, w_q});
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_olam <= r_side[NUM_W].lam;
            r_oval <= f_sat32(w_wide);
        end
    end

    assign o_valid = r_ov;
    assign o_lam   = r_olam;
    assign o_value = r_oval;

endmodule

`default_nettype wire

// File: src/spectral_pixel_calibrate_correct.sv
// ----------------------------------------------------------------------------
// spectral_pixel_calibrate_correct
// Pixel wavelength calibration with dark and reference intensity correction.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   index, sample, dark, reference
// m_axis    out  m_axis_tvalid/m_axis_tready   wavelength, value
// cfg       in   i_cfg_valid/o_cfg_ready       register index, write data
//
// One pixel per clock is accepted unless stalled; after the front pipeline and
// the queue, the back has 2 prep, 1 gain product, 40 divider stages, output reg.
// Every pixel runs the full divider so the rate never depends on the mode.
// Reset is synchronous, active low; it clears valid bits and loads register
// defaults. A full queue stalls the front; a stalled output stalls the back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "spectral_pixel_calibrate_correct_defines.svh"

module spectral_pixel_calibrate_correct import spc_pkg::*; #(
    parameter int PIXEL_OFFSET = 0,
    parameter int PIXEL_COUNT  = 4096
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    // index[11:0], sample[27:12], dark[43:28], reference[59:44], zero pad
    input  wire [TDATA_W-1:0]    s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    // wavelength[27:0], value[59:28], zero pad
    output logic [TDATA_W-1:0]   m_axis_tdata,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [COEF_W-1:0]     i_cfg_data
);

    logic [COEF_W-1:0] r_c0, r_c1, r_c2, r_c3;
    logic [LAM_W-1:0]  r_lmin, r_lmax;
    logic [1:0]        r_method;
    logic [GAIN_W-1:0] r_gain;
    t_spc_pix          w_pix;
    t_spc_item         w_fitem, w_bitem;
    t_spc_qstat        w_qstat;
    logic              w_push, w_pop;
    logic [LAM_W-1:0]  w_lam;
    logic [VAL_W-1:0]  w_val;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0     <= '0;
            r_c1     <= '0;
            r_c2     <= '0;
            r_c3     <= '0;
            r_lmin   <= LAMBDA_MIN_RST;
            r_lmax   <= LAMBDA_MAX_RST;
            r_method <= METHOD_RAW;
            r_gain   <= CAL_GAIN_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_COEFF_INTERCEPT: r_c0     <= i_cfg_data;
                REG_COEFF_LINEAR:    r_c1     <= i_cfg_data;
                REG_COEFF_SQUARE:    r_c2     <= i_cfg_data;
                REG_COEFF_CUBE:      r_c3     <= i_cfg_data;
                REG_LAMBDA_MIN:      r_lmin   <= i_cfg_data[LAM_W-1:0];
                REG_LAMBDA_MAX:      r_lmax   <= i_cfg_data[LAM_W-1:0];
                REG_METHOD:          r_method <= i_cfg_data[1:0];
                REG_CAL_GAIN:        r_gain   <= i_cfg_data[GAIN_W-1:0];
                default:             r_c0     <= r_c0;
            endcase
        end
    end

    assign w_pix = '{sample:    s_axis_tdata[27:12],
                     dark:      s_axis_tdata[43:28],
                     reference: s_axis_tdata[59:44]};

    spc_front #(
        .PIXEL_OFFSET (PIXEL_OFFSET),
        .PIXEL_COUNT  (PIXEL_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_index      (s_axis_tdata[IDX_W-1:0]),
        .i_pix        (w_pix),
        .i_coeff0     (r_c0),
        .i_coeff1     (r_c1),
        .i_coeff2     (r_c2),
        .i_coeff3     (r_c3),
        .i_lambda_min (r_lmin),
        .i_lambda_max (r_lmax),
        .i_qstat      (w_qstat),
        .o_push       (w_push),
        .o_item       (w_fitem)
    );

    spc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fitem),
        .i_pop   (w_pop),
        .o_item  (w_bitem),
        .o_qstat (w_qstat)
    );

    spc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qstat  (w_qstat),
        .i_item   (w_bitem),
        .o_pop    (w_pop),
        .i_method (r_method),
        .i_gain   (r_gain),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_lam    (w_lam),
        .o_value  (w_val)
    );

    assign m_axis_tdata = {4'b0, w_val, w_lam};

    // Queue bookkeeping and window consistency
    `SPC_NEVER(a_q_overflow, w_push && w_qstat.full, "push into full queue")
    `SPC_NEVER(a_q_underflow, w_pop && w_qstat.empty, "pop from empty queue")
    `SPC_ASSERT(a_out_in_window, m_axis_tvalid |-> (w_lam >= r_lmin && w_lam <= r_lmax), "result outside window")

endmodule

`default_nettype wire
